>>> rtl/hex_record_checker_framer_top_macros.svh
// assertion macros for the hex record checker and framer
// included by modules that carry concurrent assertions; needs a clock and reset in scope
`ifndef HEX_RECORD_CHECKER_FRAMER_TOP_MACROS_SVH
`define HEX_RECORD_CHECKER_FRAMER_TOP_MACROS_SVH

// plain property, checked on every rising edge outside reset
`define HRCF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// same-cycle implication
`define HRCF_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HRCF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/hrcf_pkg.sv
// shared types, constants and the digit decode for the hex record checker and framer
// used by hrcf_datapath, hrcf_ctrl and hex_record_checker_framer_top
package hrcf_pkg;

   localparam int MAX_DATA_DEF   = 32;
   localparam int LINE_CHARS_DEF = 256;
   localparam int REC_OVERHEAD   = 5;   // count, address high, address low, type, checksum
   localparam int REC_HDR        = 4;   // bytes ahead of the data

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] BYTE_FF  = 8'hFF;
   localparam logic [7:0] BYTE_00  = 8'h00;

   localparam logic [7:0] TYPE_DATA = 8'h00;
   localparam logic [7:0] TYPE_EOF  = 8'h01;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [2:0] ST_FRAME    = 3'd0;
   localparam logic [2:0] ST_FORMAT   = 3'd1;
   localparam logic [2:0] ST_LENGTH   = 3'd2;
   localparam logic [2:0] ST_CHECKSUM = 3'd3;
   localparam logic [2:0] ST_DONE     = 3'd4;

   typedef enum logic [1:0] {
      VD_SKIP   = 2'd0,
      VD_FRAME  = 2'd1,
      VD_RESULT = 2'd2
   } verdict_type;

   typedef struct packed {
      logic accept;
      logic clear;
      logic load_verdict;
      logic load_frame;
      logic emit_init;
   } cmd_type;

   typedef struct packed {
      logic        line_end;
      logic        out_free;
      verdict_type verdict;
      logic        frame_last;
   } sts_type;

   // loose digit rule: anything below '0' or at 0x80 and above is zero
   function automatic logic [5:0] digit_value(input logic [7:0] c);
      logic [7:0] v;
      begin
         if (c >= 8'h80)      v = 8'h00;
         else if (c >= 8'h61) v = c - 8'h61 + 8'd10;
         else if (c >= 8'h41) v = c - 8'h41 + 8'd10;
         else if (c >= 8'h30) v = c - 8'h30;
         else                 v = 8'h00;
         digit_value = v[5:0];
      end
   endfunction

endpackage

>>> rtl/hrcf_datapath.sv
// datapath: character hold-back, pair decode, record memory, line checks and result register
// depends on hrcf_pkg; driven by hrcf_ctrl through cmd_type, reports through sts_type
module hrcf_datapath
   import hrcf_pkg::*;
#(
   parameter int MAX_DATA   = MAX_DATA_DEF,
   parameter int LINE_CHARS = LINE_CHARS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_tdata,    // char_in
   input  logic [0:0] req_tuser,    // kind
   input  cmd_type    cmd,
   output sts_type    sts,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // out_byte
   output logic [2:0] rsp_tuser,    // status
   output logic       rsp_tlast
);

   localparam int REC_DEPTH = MAX_DATA + REC_OVERHEAD;
   localparam int IDX_W     = $clog2(REC_DEPTH);
   localparam int BC_W      = $clog2(REC_DEPTH + 1);
   localparam int CI_W      = $clog2(LINE_CHARS + 1);

   logic [7:0] rec_mem [REC_DEPTH];

   logic [BC_W-1:0]  byte_count_ff, byte_count_in;
   logic [3:0]       high_nibble_ff, high_nibble_in;
   logic             pend_ff, pend_in;
   logic [7:0]       held_char_ff, held_char_in;
   logic             held_valid_ff, held_valid_in;
   logic [CI_W-1:0]  char_index_ff, char_index_in;
   logic             colon_ff, colon_in;
   logic [7:0]       sum_ff, sum_in;
   logic [BC_W-1:0]  ff_count_ff, ff_count_in;
   logic             overflow_ff, overflow_in;
   logic             at_end_ff, at_end_in;
   logic [7:0]       rec_count_ff, rec_count_in;
   logic [7:0]       addr_hi_ff, addr_hi_in;
   logic [7:0]       addr_lo_ff, addr_lo_in;
   logic [7:0]       rec_type_ff, rec_type_in;
   logic [7:0]       last_byte_ff, last_byte_in;
   logic [IDX_W-1:0] emit_idx_ff, emit_idx_in;
   logic [7:0]       rd_q_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_last_ff, rsp_last_in;

   logic       line_end;
   logic       take_en;
   logic [5:0] dv;
   logic [7:0] pair_byte;
   logic       wr_en;
   logic       len_bad;
   logic       eof;
   logic [BC_W-1:0] data_ff;
   logic [2:0] res_status;
   logic [7:0] res_byte;
   logic [7:0] frame_byte;
   verdict_type verdict;
   logic       frame_last;
   logic       out_free;

   assign line_end  = (req_tuser[0] == KIND_END) || (req_tdata == CH_LF);
   // the held character goes in unless it is a carriage return right before a line feed
   assign take_en   = cmd.accept && held_valid_ff &&
                      (!line_end || (req_tuser[0] == KIND_END) || (held_char_ff != CH_CR));
   assign dv        = digit_value(held_char_ff);
   assign pair_byte = {high_nibble_ff, 4'b0000} + {2'b00, dv};

   always_comb begin
      byte_count_in  = byte_count_ff;
      high_nibble_in = high_nibble_ff;
      pend_in        = pend_ff;
      held_char_in   = held_char_ff;
      held_valid_in  = held_valid_ff;
      char_index_in  = char_index_ff;
      colon_in       = colon_ff;
      sum_in         = sum_ff;
      ff_count_in    = ff_count_ff;
      overflow_in    = overflow_ff;
      at_end_in      = at_end_ff;
      rec_count_in   = rec_count_ff;
      addr_hi_in     = addr_hi_ff;
      addr_lo_in     = addr_lo_ff;
      rec_type_in    = rec_type_ff;
      last_byte_in   = last_byte_ff;
      wr_en          = 1'b0;

      if (cmd.clear) begin
         byte_count_in = '0;
         pend_in       = 1'b0;
         held_valid_in = 1'b0;
         char_index_in = '0;
         colon_in      = 1'b0;
         sum_in        = '0;
         ff_count_in   = '0;
         overflow_in   = 1'b0;
      end

      if (take_en) begin
         if (char_index_ff >= CI_W'(LINE_CHARS)) begin
            overflow_in = 1'b1;
         end else begin
            char_index_in = char_index_ff + 1'b1;
            if (char_index_ff == '0) begin
               colon_in = (held_char_ff == CH_COLON);
            end else if (!pend_ff) begin
               high_nibble_in = dv[3:0];
               pend_in        = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (byte_count_ff < BC_W'(REC_DEPTH)) begin
                  wr_en         = 1'b1;
                  sum_in        = sum_ff + pair_byte;
                  byte_count_in = byte_count_ff + 1'b1;
                  last_byte_in  = pair_byte;
                  if (byte_count_ff >= BC_W'(REC_HDR) && pair_byte == BYTE_FF) begin
                     ff_count_in = ff_count_ff + 1'b1;
                  end
                  case (byte_count_ff)
                     BC_W'(0): rec_count_in = pair_byte;
                     BC_W'(1): addr_hi_in   = pair_byte;
                     BC_W'(2): addr_lo_in   = pair_byte;
                     BC_W'(3): rec_type_in  = pair_byte;
                     default: ;
                  endcase
               end else begin
                  overflow_in = 1'b1;
               end
            end
         end
      end

      if (cmd.accept) begin
         if (!line_end) begin
            held_char_in  = req_tdata;
            held_valid_in = 1'b1;
         end else begin
            held_valid_in = 1'b0;
            at_end_in     = (req_tuser[0] == KIND_END);
         end
      end
   end

   // line checks, in priority order
   assign len_bad = overflow_ff || (byte_count_ff < BC_W'(REC_OVERHEAD)) ||
                    (9'(byte_count_ff) != ({1'b0, rec_count_ff} + 9'd5));
   // the checksum byte was counted among the 0xff bytes when it is one
   assign data_ff = ff_count_ff - BC_W'(last_byte_ff == BYTE_FF);
   assign eof     = at_end_ff || (rec_type_ff == TYPE_EOF) ||
                    ((rec_type_ff == TYPE_DATA) && (8'(data_ff) == rec_count_ff));

   always_comb begin
      verdict    = VD_RESULT;
      res_status = ST_DONE;
      if (!colon_ff) begin
         res_status = ST_FORMAT;
      end else if (len_bad) begin
         res_status = ST_LENGTH;
      end else if (sum_ff != 8'h00) begin
         res_status = ST_CHECKSUM;
      end else if (eof) begin
         res_status = ST_DONE;
      end else if (rec_type_ff == TYPE_DATA) begin
         verdict = VD_FRAME;
      end else begin
         verdict = VD_SKIP;
      end
   end

   assign res_byte = (res_status == ST_DONE) ? BYTE_00 : CH_MINUS;

   always_comb begin
      case (emit_idx_ff)
         IDX_W'(0): frame_byte = CH_PLUS;
         IDX_W'(1): frame_byte = addr_hi_ff;
         IDX_W'(2): frame_byte = addr_lo_ff;
         IDX_W'(3): frame_byte = rec_count_ff;
         default:   frame_byte = rd_q_ff;
      endcase
   end

   // frame holds count + 4 bytes, that is byte_count - 1
   assign frame_last = (BC_W'(emit_idx_ff) == (byte_count_ff - BC_W'(2)));
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      emit_idx_in = emit_idx_ff;
      if (cmd.emit_init) begin
         emit_idx_in = '0;
      end else if (cmd.load_frame && !frame_last) begin
         emit_idx_in = emit_idx_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.load_verdict) begin
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = res_byte;
         rsp_status_in = res_status;
         rsp_last_in   = 1'b1;
      end else if (cmd.load_frame) begin
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = frame_byte;
         rsp_status_in = ST_FRAME;
         rsp_last_in   = frame_last;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rec_mem[byte_count_ff[IDX_W-1:0]] <= pair_byte;
      end
      // read ahead at the next index so data is ready when that byte is loaded
      rd_q_ff <= rec_mem[emit_idx_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         pend_ff       <= 1'b0;
         held_valid_ff <= 1'b0;
         char_index_ff <= '0;
         colon_ff      <= 1'b0;
         sum_ff        <= '0;
         ff_count_ff   <= '0;
         overflow_ff   <= 1'b0;
         at_end_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         byte_count_ff <= byte_count_in;
         pend_ff       <= pend_in;
         held_valid_ff <= held_valid_in;
         char_index_ff <= char_index_in;
         colon_ff      <= colon_in;
         sum_ff        <= sum_in;
         ff_count_ff   <= ff_count_in;
         overflow_ff   <= overflow_in;
         at_end_ff     <= at_end_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      high_nibble_ff <= high_nibble_in;
      held_char_ff   <= held_char_in;
      rec_count_ff   <= rec_count_in;
      addr_hi_ff     <= addr_hi_in;
      addr_lo_ff     <= addr_lo_in;
      rec_type_ff    <= rec_type_in;
      last_byte_ff   <= last_byte_in;
      emit_idx_ff    <= emit_idx_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign sts.line_end   = line_end;
   assign sts.out_free   = out_free;
   assign sts.verdict    = verdict;
   assign sts.frame_last = frame_last;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> rtl/hrcf_ctrl.sv
// controller: takes characters, runs the line-end check and frame replay, halts on error or done
// depends on hrcf_pkg and the assertion macros header; drives hrcf_datapath through cmd_type
`include "hex_record_checker_framer_top_macros.svh"

module hrcf_ctrl
   import hrcf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_FINISH = 4'b0010,
      S_EMIT   = 4'b0100,
      S_HALT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            if (req_tvalid && sts.line_end) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            case (sts.verdict)
               VD_SKIP: begin
                  cmd.clear = 1'b1;
                  state_in  = S_IDLE;
               end
               VD_FRAME: begin
                  cmd.emit_init = 1'b1;
                  state_in      = S_EMIT;
               end
               VD_RESULT: begin
                  if (sts.out_free) begin
                     cmd.load_verdict = 1'b1;
                     state_in         = S_HALT;
                  end
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.load_frame = 1'b1;
               if (sts.frame_last) begin
                  cmd.clear = 1'b1;
                  state_in  = S_IDLE;
               end
            end
         end
         S_HALT: begin
            // items are still taken and dropped until reset
            req_tready = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `HRCF_ASSERT_NEXT(a_halt_sticks, state_ff == S_HALT, state_ff == S_HALT, "halt state left")
   `HRCF_ASSERT_NEXT(a_verdict_halts, cmd.load_verdict, state_ff == S_HALT, "no halt after result")
   `HRCF_ASSERT_IMPL(a_load_needs_room, cmd.load_frame || cmd.load_verdict, sts.out_free,
                     "result loaded over a waiting item")
   `HRCF_ASSERT_NEXT(a_clear_to_idle, cmd.clear, state_ff == S_IDLE, "line cleared outside return")
   `HRCF_ASSERT(a_accept_only_idle, !cmd.accept || (state_ff == S_IDLE), "item taken outside idle")

endmodule

>>> rtl/hex_record_checker_framer_top.sv
// Intel HEX record checker and framer: takes the file text one character per item and
// checks each line for the leading colon, the record length and the checksum. A data
// record that does not end the file comes out as the frame '+', address high, address
// low, count, data, with tlast on the final byte; other record types give nothing; an
// error gives one '-' item with its status and an end-of-file record or end of input
// gives one done item, and after either the block drops all input until reset.
// Timing: characters are taken while the block is idle, and the checks run in the cycle
// after a line end; a data record then replays count + 4 bytes, one per cycle while rsp_tready
// is high, paced by the single output register and one record-memory read per byte.
// Depends on hrcf_pkg, hrcf_ctrl and hrcf_datapath.
module hex_record_checker_framer_top
   import hrcf_pkg::*;
#(
   parameter int MAX_DATA   = MAX_DATA_DEF,
   parameter int LINE_CHARS = LINE_CHARS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] char_in
   input  logic [0:0] req_tuser,    // [0] kind
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] out_byte
   output logic [2:0] rsp_tuser,    // [2:0] status
   output logic       rsp_tlast
);

   cmd_type cmd;
   sts_type sts;

   hrcf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   hrcf_datapath #(
      .MAX_DATA   (MAX_DATA),
      .LINE_CHARS (LINE_CHARS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> bench/hex_record_checker_framer_top_tb.sv
`timescale 1ns / 1ps
// testbench for hex_record_checker_framer_top: feeds hex record text, checks framed bytes,
// error items and the done item against a line decoder kept in the bench
// depends on hrcf_pkg and the hex_record_checker_framer_top rtl
module hex_record_checker_framer_top_tb
   import hrcf_pkg::*;
();

   localparam int REC_DEPTH   = MAX_DATA_DEF + REC_OVERHEAD;
   localparam int CYCLE_LIMIT = 400000;

   localparam logic [7:0] ASC_0  = "0";
   localparam logic [7:0] ASC_UA = "A";
   localparam logic [7:0] ASC_LA = "a";
   localparam logic [7:0] ASC_F  = "F";

   typedef struct packed {
      logic       kind;
      logic [7:0] ch;
   } hex_char_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] status;
      logic       last;
   } framer_out_type;

   typedef enum logic [1:0] {
      SINK_OPEN  = 2'd0,
      SINK_COIN  = 2'd1,
      SINK_SLOW  = 2'd2,
      SINK_PULSE = 2'd3
   } sink_mode_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = '0;    // [7:0] char_in
   logic [0:0] req_tuser  = '0;    // [0] kind
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;          // [7:0] out_byte
   logic [2:0] rsp_tuser;          // [2:0] status
   logic       rsp_tlast;

   hex_char_type   hex_chars_q[$];
   framer_out_type framer_out_q[$];

   // decoder state for the line in progress
   logic [7:0] rec_mem [REC_DEPTH];
   int         ln_nbytes   = 0;
   int         ln_chars    = 0;
   logic [7:0] ln_hi_char  = '0;
   logic       ln_nib_pend = 1'b0;
   logic [7:0] held_c      = '0;
   logic       held_v      = 1'b0;
   logic       ln_colon    = 1'b0;
   logic [7:0] ln_sum      = '0;
   logic [7:0] ln_ff       = '0;
   logic       ln_over     = 1'b0;
   logic       file_closed = 1'b0;

   int            cycle_count    = 0;
   int            mismatch_count = 0;
   int            chars_taken    = 0;
   int            total_chars    = 0;
   logic          req_taken      = 1'b0;
   int            gap_left       = 0;
   int            burst_left     = 1;
   hex_char_type  drv_item;
   sink_mode_type sink_mode      = SINK_OPEN;
   int            sink_hold      = 0;
   framer_out_type want;

   hex_record_checker_framer_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // loose digit rule of the file format
   function automatic logic [7:0] hex_digit(input logic [7:0] c);
      if (c[7]) return 8'd0;
      if (c >= ASC_LA) return c - ASC_LA + 8'd10;
      if (c >= ASC_UA) return c - ASC_UA + 8'd10;
      if (c >= ASC_0) return c - ASC_0;
      return 8'd0;
   endfunction

   // high digit keeps its low nibble, low digit is added in full
   function automatic logic [7:0] pair_value(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] hi;
      hi = hex_digit(a);
      return {hi[3:0], 4'h0} + hex_digit(b);
   endfunction

   task automatic push_framer_out(input logic [7:0] b, input logic [2:0] st, input logic lst);
      framer_out_type r;
      r.out_byte = b;
      r.status   = st;
      r.last     = lst;
      framer_out_q.push_back(r);
   endtask

   task automatic line_take(input logic [7:0] c);
      logic [7:0] b;
      if (ln_chars >= LINE_CHARS_DEF) begin
         ln_over = 1'b1;
      end else begin
         if (ln_chars == 0) begin
            ln_colon = (c == CH_COLON);
         end else if (!ln_nib_pend) begin
            ln_hi_char  = c;
            ln_nib_pend = 1'b1;
         end else begin
            b = pair_value(ln_hi_char, c);
            ln_nib_pend = 1'b0;
            if (ln_nbytes < REC_DEPTH) begin
               rec_mem[ln_nbytes] = b;
               if (ln_nbytes >= REC_HDR && b == BYTE_FF) ln_ff = ln_ff + 8'd1;
               ln_sum = ln_sum + b;
               ln_nbytes++;
            end else begin
               ln_over = 1'b1;
            end
         end
         ln_chars++;
      end
   endtask

   task automatic line_close(input logic at_end);
      logic [7:0] cnt;
      logic [7:0] rtype;
      logic [7:0] data_ff;
      logic [7:0] b;
      logic       eof;
      int         total;
      if (!ln_colon) begin
         push_framer_out(CH_MINUS, ST_FORMAT, 1'b1);
         file_closed = 1'b1;
      end else if (ln_over || ln_nbytes < REC_OVERHEAD ||
                   ln_nbytes != int'(rec_mem[0]) + REC_OVERHEAD) begin
         push_framer_out(CH_MINUS, ST_LENGTH, 1'b1);
         file_closed = 1'b1;
      end else if (ln_sum != BYTE_00) begin
         push_framer_out(CH_MINUS, ST_CHECKSUM, 1'b1);
         file_closed = 1'b1;
      end else begin
         cnt     = rec_mem[0];
         rtype   = rec_mem[3];
         data_ff = ln_ff;
         // the checksum byte is not data
         if (rec_mem[ln_nbytes-1] == BYTE_FF) data_ff = data_ff - 8'd1;
         eof = at_end || rtype == TYPE_EOF || (rtype == TYPE_DATA && data_ff == cnt);
         if (eof) begin
            push_framer_out(BYTE_00, ST_DONE, 1'b1);
            file_closed = 1'b1;
         end else if (rtype == TYPE_DATA) begin
            total = int'(cnt) + REC_HDR;
            for (int i = 0; i < total; i++) begin
               case (i)
                  0:       b = CH_PLUS;
                  1:       b = rec_mem[1];
                  2:       b = rec_mem[2];
                  3:       b = cnt;
                  default: b = rec_mem[i];
               endcase
               push_framer_out(b, ST_FRAME, i == total - 1);
            end
         end
      end
      ln_nbytes   = 0;
      ln_chars    = 0;
      ln_hi_char  = '0;
      ln_nib_pend = 1'b0;
      held_c      = '0;
      held_v      = 1'b0;
      ln_colon    = 1'b0;
      ln_sum      = '0;
      ln_ff       = '0;
      ln_over     = 1'b0;
   endtask

   task automatic hex_line_step(input logic kind, input logic [7:0] c);
      if (!file_closed) begin
         if (kind == KIND_CHAR && c != CH_LF) begin
            if (held_v) line_take(held_c);
            held_c = c;
            held_v = 1'b1;
         end else begin
            // a carriage return right before the line feed is dropped
            if (held_v && (kind == KIND_END || held_c != CH_CR)) line_take(held_c);
            held_v = 1'b0;
            line_close(kind == KIND_END);
         end
      end
   endtask

   // stimulus builders
   task automatic push_char(input logic [7:0] c);
      hex_char_type it;
      it.kind = KIND_CHAR;
      it.ch   = c;
      hex_chars_q.push_back(it);
   endtask

   task automatic push_end();
      hex_char_type it;
      it.kind = KIND_END;
      it.ch   = 8'($urandom_range(0, 255));
      hex_chars_q.push_back(it);
   endtask

   function automatic logic [7:0] nib_char(input logic [3:0] n, input bit lower);
      if (n < 4'd10) return ASC_0 + n;
      return (lower ? ASC_LA : ASC_UA) + n - 8'd10;
   endfunction

   function automatic logic [7:0] loose_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
      return c;
   endfunction

   task automatic push_hex(input logic [7:0] b, input bit lower);
      push_char(nib_char(b[7:4], lower));
      push_char(nib_char(b[3:0], lower));
   endtask

   task automatic emit_record(input int cnt, input logic [7:0] count_field,
                              input logic [7:0] rtype, input int loose_pct, input bit crlf,
                              input bit odd, input logic [7:0] sum_skew,
                              input bit close_line, input bit all_ff);
      logic [7:0] hi_c[$];
      logic [7:0] lo_c[$];
      logic [7:0] b;
      logic [7:0] sum;
      logic [15:0] addr;
      bit lower;
      bit any_not_ff;
      lower      = 1'($urandom_range(0, 1));
      addr       = 16'($urandom);
      any_not_ff = 1'b0;
      for (int i = 0; i < cnt; i++) begin
         if (all_ff) begin
            hi_c.push_back(ASC_F);
            lo_c.push_back(ASC_F);
         end else if ($urandom_range(0, 99) < loose_pct) begin
            hi_c.push_back(loose_char());
            lo_c.push_back(loose_char());
         end else begin
            b = 8'($urandom_range(0, 255));
            hi_c.push_back(nib_char(b[7:4], lower));
            lo_c.push_back(nib_char(b[3:0], lower));
         end
         if (pair_value(hi_c[i], lo_c[i]) != BYTE_FF) any_not_ff = 1'b1;
      end
      // all-0xFF data would end the file
      if (!all_ff && rtype == TYPE_DATA && cnt > 0 && !any_not_ff) begin
         hi_c[0] = ASC_0;
         lo_c[0] = ASC_0;
      end
      push_char(CH_COLON);
      push_hex(count_field, lower);
      push_hex(addr[15:8], lower);
      push_hex(addr[7:0], lower);
      push_hex(rtype, lower);
      sum = count_field + addr[15:8] + addr[7:0] + rtype;
      for (int i = 0; i < cnt; i++) begin
         push_char(hi_c[i]);
         push_char(lo_c[i]);
         sum = sum + pair_value(hi_c[i], lo_c[i]);
      end
      push_hex(8'd0 - sum + sum_skew, lower);
      if (odd) push_char(loose_char());
      if (crlf) push_char(CH_CR);
      if (close_line) push_char(CH_LF);
   endtask

   task automatic emit_random_line();
      int cnt;
      if ($urandom_range(0, 99) < 15) begin
         cnt = $urandom_range(0, 6);
         emit_record(cnt, 8'(cnt), 8'($urandom_range(2, 255)), 0, $urandom_range(0, 2) == 0,
                     $urandom_range(0, 2) == 0, 8'd0, 1'b1, 1'b0);
      end else begin
         cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(9, MAX_DATA_DEF)
                                           : $urandom_range(1, 8);
         emit_record(cnt, 8'(cnt), TYPE_DATA, ($urandom_range(0, 3) == 0) ? 40 : 0,
                     $urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0, 8'd0, 1'b1, 1'b0);
      end
   endtask

   // the line that stops the file: an error, a record that ends the file or end of input
   task automatic emit_closing_line();
      int cnt;
      int n;
      logic [7:0] c;
      cnt = $urandom_range(1, 6);
      case ($urandom_range(0, 10))
         0: begin
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) begin
               c = loose_char();
               push_char((i == 0 && c == CH_COLON) ? ASC_0 : c);
            end
            push_char(CH_LF);
         end
         1: emit_record(cnt, 8'(cnt + $urandom_range(1, 3)), TYPE_DATA, 0, 1'b0, 1'b0, 8'd0,
                        1'b1, 1'b0);
         2: begin
            push_char(CH_COLON);
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) push_hex(8'($urandom_range(0, 255)), 1'b0);
            push_char(CH_LF);
         end
         3: begin
            cnt = $urandom_range(MAX_DATA_DEF + 1, 45);
            emit_record(cnt, 8'(cnt), TYPE_DATA, 0, 1'b0, 1'b0, 8'd0, 1'b1, 1'b0);
         end
         4: begin
            push_char(CH_COLON);
            n = $urandom_range(LINE_CHARS_DEF + 1, 320);
            for (int i = 0; i < n; i++) push_char(ASC_0);
            push_char(CH_LF);
         end
         5: emit_record(cnt, 8'(cnt), TYPE_DATA, 0, 1'b0, 1'b0, 8'($urandom_range(1, 255)),
                        1'b1, 1'b0);
         6: emit_record($urandom_range(0, 4), 8'd0, TYPE_EOF, 0, 1'b0, 1'b0, 8'd0, 1'b1,
                        1'b0);
         7: emit_record(cnt, 8'(cnt), TYPE_DATA, 0, 1'b1, 1'b0, 8'd0, 1'b1, 1'b1);
         8: emit_record(0, 8'd0, TYPE_DATA, 0, 1'b0, 1'b0, 8'd0, 1'b1, 1'b0);
         9: emit_record(cnt, 8'(cnt), ($urandom_range(0, 1) == 0) ? TYPE_DATA : 8'h05, 0,
                        $urandom_range(0, 1) == 0, $urandom_range(0, 1) == 0, 8'd0, 1'b0, 1'b0);
         default: ;
      endcase
      // end of input: closes the line in progress, or is dropped when the block has halted
      push_end();
   endtask

   // sender: bursts with random gaps, one item held until taken
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (hex_chars_q.size() > 0) begin
            drv_item = hex_chars_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= drv_item.ch;
            req_tuser  <= drv_item.kind;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: a random stall pattern, picked anew whenever its hold count runs out
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (sink_hold == 0) begin
            sink_mode <= sink_mode_type'($urandom_range(0, 3));
            sink_hold <= $urandom_range(40, 300);
         end else begin
            sink_hold <= sink_hold - 1;
         end
         case (sink_mode)
            SINK_OPEN:  rsp_tready <= 1'b1;
            SINK_COIN:  rsp_tready <= ($urandom_range(0, 1) == 1);
            SINK_SLOW:  rsp_tready <= ($urandom_range(0, 3) == 0);
            default:    rsp_tready <= (cycle_count % 5 != 0);
         endcase
      end
   end

   // results are checked before this edge's input item is decoded
   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (rsp_tvalid && rsp_tready) begin
            if (framer_out_q.size() == 0) begin
               $display("%0t: unexpected item: byte %02h status %0d last %0b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
               mismatch_count++;
            end else begin
               want = framer_out_q.pop_front();
               if (rsp_tdata !== want.out_byte || rsp_tuser !== want.status ||
                   rsp_tlast !== want.last) begin
                  $display("%0t: expected %02h/%0d/%0b, got %02h/%0d/%0b",
                           $time, want.out_byte, want.status, want.last,
                           rsp_tdata, rsp_tuser, rsp_tlast);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            hex_line_step(req_tuser[0], req_tdata);
            chars_taken++;
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("hex_record_checker_framer_top_tb NOT OK");
      $finish;
   end

   initial begin
      // directed lines: shortest and longest data records, other types, noisy digits
      emit_record(1, 8'd1, TYPE_DATA, 0, 1'b0, 1'b0, 8'd0, 1'b1, 1'b0);
      emit_record(MAX_DATA_DEF, 8'(MAX_DATA_DEF), TYPE_DATA, 0, 1'b1, 1'b0, 8'd0, 1'b1, 1'b0);
      emit_record(2, 8'd2, 8'h02, 0, 1'b0, 1'b1, 8'd0, 1'b1, 1'b0);
      emit_record(3, 8'd3, 8'hFF, 100, 1'b1, 1'b1, 8'd0, 1'b1, 1'b0);
      emit_record(2, 8'd2, TYPE_DATA, 100, 1'b0, 1'b1, 8'd0, 1'b1, 1'b0);
      while (hex_chars_q.size() < 270) emit_random_line();
      emit_closing_line();
      total_chars = hex_chars_q.size();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (chars_taken < total_chars || framer_out_q.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("hex_record_checker_framer_top_tb OK");
      end else begin
         $display("hex_record_checker_framer_top_tb NOT OK");
      end
      $finish;
   end

endmodule
